// ===== hdl/mcr_pkg.sv =====
// Shared types and constants for the midpoint circle rasterizer.
`timescale 1ns / 1ps

package mcr_pkg;

  // Fixed field widths of the item channels
  localparam int COORD_W  = 16;
  localparam int RADIUS_W = 12;

  // Decision value is a 16-bit wrapping quantity
  localparam int DEC_W = 16;

  // Opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Decision constants: d0 = 3 - 2r, d += 4x + 6, d += 4(x - y) + 10
  localparam logic signed [DEC_W-1:0] DEC_INIT     = 16'sd3;
  localparam logic signed [DEC_W-1:0] DEC_FLAT_INC = 16'sd6;
  localparam logic signed [DEC_W-1:0] DEC_DIAG_INC = 16'sd10;
  localparam int                      DEC_SCALE_SH = 2;  // multiply by 4

  // Eight mirrored points per group
  localparam int MIRROR_N = 8;
  localparam int MIRROR_W = 3;

  typedef struct packed {
    logic                       opcode;
    logic signed [COORD_W-1:0]  center_x;
    logic signed [COORD_W-1:0]  center_y;
    logic        [RADIUS_W-1:0] radius;
  } mcr_cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic                      last_of_group;
    logic                      circle_done;
  } mcr_pix_t;

endpackage

// ===== hdl/mcr_fifo.sv =====
// Small register FIFO between the front and back ends.
`timescale 1ns / 1ps

module mcr_fifo #(
  parameter int WIDTH = 59,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             not_full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_full  = (count != CNT_FULL);
  assign not_empty = (count != '0);
  assign rd_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> not_full)
    else $error("fifo written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> not_empty)
    else $error("fifo read while empty");

endmodule

// ===== hdl/mcr_front.sv =====
// Front end: takes items, runs the midpoint recurrence, queues point groups.
`timescale 1ns / 1ps

module mcr_front #(
  parameter int RADIUS_BITS = 12,
  parameter int COORD_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  mcr_pkg::mcr_cmd_t            cmd,
  input  logic                         q_ready,
  output logic                         q_push,
  output logic signed [COORD_BITS-1:0] q_cx,
  output logic signed [COORD_BITS-1:0] q_cy,
  output logic signed [RADIUS_BITS:0]  q_ox,
  output logic signed [RADIUS_BITS:0]  q_oy,
  output logic                         q_done
);

  localparam int OFS_W = RADIUS_BITS + 1;
  localparam int EXT_W = mcr_pkg::RADIUS_W + OFS_W;
  localparam int DW    = mcr_pkg::DEC_W;
  localparam logic [EXT_W-1:0] RMASK = (EXT_W'(1) << RADIUS_BITS) - EXT_W'(1);

  // Circle state
  logic signed [OFS_W-1:0]      ox;
  logic signed [OFS_W-1:0]      oy;
  logic signed [DW-1:0]         dec;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic                         active;

  logic signed [OFS_W-1:0]      ox_next;
  logic signed [OFS_W-1:0]      oy_next;
  logic signed [DW-1:0]         dec_next;
  logic signed [COORD_BITS-1:0] cx_next;
  logic signed [COORD_BITS-1:0] cy_next;
  logic                         active_next;

  logic                    accept;
  logic                    is_start;
  logic signed [OFS_W-1:0] r_start;
  logic signed [DW-1:0]    r16;
  logic signed [DW-1:0]    x4;
  logic signed [DW-1:0]    y4;
  logic signed [DW-1:0]    dec_flat;
  logic signed [DW-1:0]    dec_diag;
  logic                    dec_nonpos;
  logic signed [OFS_W-1:0] ox_step;
  logic signed [OFS_W-1:0] oy_step;
  logic                    done_step;

  assign cmd_ready = q_ready;
  assign accept    = cmd_valid && cmd_ready;
  assign is_start  = (cmd.opcode == mcr_pkg::OP_START);

  assign r_start = OFS_W'(EXT_W'(cmd.radius) & RMASK);
  assign r16     = DW'(r_start);
  assign x4      = DW'(ox) <<< mcr_pkg::DEC_SCALE_SH;
  assign y4      = DW'(oy) <<< mcr_pkg::DEC_SCALE_SH;

  assign dec_nonpos = dec[DW-1] || (dec == '0);
  assign dec_flat   = dec + x4 + mcr_pkg::DEC_FLAT_INC;
  assign dec_diag   = dec + x4 - y4 + mcr_pkg::DEC_DIAG_INC;
  assign ox_step    = ox + OFS_W'(1);
  assign oy_step    = dec_nonpos ? oy : oy - OFS_W'(1);
  assign done_step  = (ox_step > oy_step);

  always_comb begin
    ox_next     = ox;
    oy_next     = oy;
    dec_next    = dec;
    cx_next     = cx;
    cy_next     = cy;
    active_next = active;
    q_push      = 1'b0;
    q_done      = 1'b0;
    if (accept) begin
      if (is_start) begin
        ox_next     = '0;
        oy_next     = r_start;
        dec_next    = mcr_pkg::DEC_INIT - (r16 <<< 1);
        cx_next     = COORD_BITS'(cmd.center_x);
        cy_next     = COORD_BITS'(cmd.center_y);
        active_next = 1'b1;
        q_push      = 1'b1;
      end else if (active) begin
        ox_next     = ox_step;
        oy_next     = oy_step;
        dec_next    = dec_nonpos ? dec_flat : dec_diag;
        active_next = !done_step;
        q_push      = 1'b1;
        q_done      = done_step;
      end
    end
  end

  // Queued group carries the updated offsets
  assign q_cx = cx_next;
  assign q_cy = cy_next;
  assign q_ox = ox_next;
  assign q_oy = oy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ox     <= '0;
      oy     <= '0;
      dec    <= '0;
      cx     <= '0;
      cy     <= '0;
      active <= 1'b0;
    end else begin
      ox     <= ox_next;
      oy     <= oy_next;
      dec    <= dec_next;
      cx     <= cx_next;
      cy     <= cy_next;
      active <= active_next;
    end
  end

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.opcode == mcr_pkg::OP_STEP && active && done_step) |=> !active)
    else $error("circle still active after its final step");

endmodule

// ===== hdl/mcr_back.sv =====
// Back end: expands one queued group into eight mirrored points.
`timescale 1ns / 1ps

module mcr_back #(
  parameter int RADIUS_BITS = 12,
  parameter int COORD_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  logic signed [COORD_BITS-1:0] q_cx,
  input  logic signed [COORD_BITS-1:0] q_cy,
  input  logic signed [RADIUS_BITS:0]  q_ox,
  input  logic signed [RADIUS_BITS:0]  q_oy,
  input  logic                         q_done,
  output logic                         pix_valid,
  input  logic                         pix_ready,
  output mcr_pkg::mcr_pix_t            pix
);

  localparam int MW = mcr_pkg::MIRROR_W;
  localparam int PW = mcr_pkg::COORD_W;
  localparam logic [MW-1:0] LAST_K = MW'(mcr_pkg::MIRROR_N - 1);

  logic [MW-1:0] k;
  logic          load;
  logic          last;
  logic          swap;
  logic          neg_a;
  logic          neg_b;

  logic signed [RADIUS_BITS:0]  off_a;
  logic signed [RADIUS_BITS:0]  off_b;
  logic signed [COORD_BITS-1:0] off_a_c;
  logic signed [COORD_BITS-1:0] off_b_c;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;

  assign load  = q_valid && (!pix_valid || pix_ready);
  assign last  = (k == LAST_K);
  assign q_pop = load && last;

  // Order: (x,y) (x,-y) (-x,-y) (-x,y) then the same with x and y swapped
  assign swap  = k[2];
  assign neg_a = k[1];
  assign neg_b = k[1] ^ k[0];

  assign off_a   = swap ? q_oy : q_ox;
  assign off_b   = swap ? q_ox : q_oy;
  assign off_a_c = COORD_BITS'(off_a);
  assign off_b_c = COORD_BITS'(off_b);
  assign px      = neg_a ? q_cx - off_a_c : q_cx + off_a_c;
  assign py      = neg_b ? q_cy - off_b_c : q_cy + off_b_c;

  always_ff @(posedge clk) begin
    if (load) begin
      pix.pixel_x       <= PW'(px);
      pix.pixel_y       <= PW'(py);
      pix.last_of_group <= last;
      pix.circle_done   <= q_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      pix_valid <= 1'b0;
    end else begin
      if (load) begin
        k         <= k + MW'(1);
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
    end
  end

  a_last_tracks_count: assert property (@(posedge clk) disable iff (rst)
    load |=> (pix.last_of_group == (k == '0)))
    else $error("last_of_group out of step with point counter");

endmodule

// ===== hdl/midpoint_circle_rasterizer.sv =====
// Top level of the midpoint circle rasterizer.
// The first point of an item passes the group queue, then the back end's point output register.
// Throughput: a start or active step yields eight points, one per cycle while pix_ready
//   holds; the point output register of the back end sets that rate.
// A step while idle yields nothing; a two-group queue
//   lets the front take items while the back is still emitting.
// Reset (synchronous, rst high) clears the circle state to idle and empties the queue.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer #(
  parameter int RADIUS_BITS = 12,
  parameter int COORD_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  mcr_pkg::mcr_cmd_t cmd,
  output logic              pix_valid,
  input  logic              pix_ready,
  output mcr_pkg::mcr_pix_t pix
);

  // Offsets are signed and one bit wider than the radius: a zero radius steps to y = -1
  localparam int OFS_W  = RADIUS_BITS + 1;
  // Queue entry: centre x, centre y, offset x, offset y, done flag
  localparam int QW     = 2 * COORD_BITS + 2 * OFS_W + 1;
  localparam int QDEPTH = 2;

  logic                         q_push;
  logic                         q_ready;
  logic signed [COORD_BITS-1:0] f_cx;
  logic signed [COORD_BITS-1:0] f_cy;
  logic signed [OFS_W-1:0]      f_ox;
  logic signed [OFS_W-1:0]      f_oy;
  logic                         f_done;
  logic [QW-1:0]                q_wr_data;
  logic [QW-1:0]                q_rd_data;
  logic                         q_valid;
  logic                         q_pop;
  logic signed [COORD_BITS-1:0] b_cx;
  logic signed [COORD_BITS-1:0] b_cy;
  logic signed [OFS_W-1:0]      b_ox;
  logic signed [OFS_W-1:0]      b_oy;
  logic                         b_done;

  // Front: decodes start/step, advances x, y and the decision value
  mcr_front #(
    .RADIUS_BITS(RADIUS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_cx     (f_cx),
    .q_cy     (f_cy),
    .q_ox     (f_ox),
    .q_oy     (f_oy),
    .q_done   (f_done)
  );

  assign q_wr_data = {f_cx, f_cy, f_ox, f_oy, f_done};

  // Group queue decouples the recurrence from point emission
  mcr_fifo #(
    .WIDTH(QW),
    .DEPTH(QDEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wr_data),
    .not_full (q_ready),
    .rd_en    (q_pop),
    .rd_data  (q_rd_data),
    .not_empty(q_valid)
  );

  assign {b_cx, b_cy, b_ox, b_oy, b_done} = q_rd_data;

  // Back: mirrors the group into eight points, wraps them to the coordinate width
  mcr_back #(
    .RADIUS_BITS(RADIUS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cx     (b_cx),
    .q_cy     (b_cy),
    .q_ox     (b_ox),
    .q_oy     (b_oy),
    .q_done   (b_done),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix      (pix)
  );

endmodule

// ===== tb/sv/mcr_pixel_checker.sv =====
// Predicts the point stream of the midpoint circle rasterizer and checks the block's output.
`timescale 1ns / 1ps

module mcr_pixel_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              cmd_ready,
  input  mcr_pkg::mcr_cmd_t cmd,
  input  logic              pix_valid,
  input  logic              pix_ready,
  input  mcr_pkg::mcr_pix_t pix,
  output int                fail_count,
  output int                points_pending
);

  // circle state: offsets from the centre, decision value, latched centre
  logic signed [12:0]                 arc_x;
  logic signed [12:0]                 arc_y;
  logic signed [mcr_pkg::DEC_W-1:0]   decision;
  logic signed [mcr_pkg::COORD_W-1:0] ctr_x;
  logic signed [mcr_pkg::COORD_W-1:0] ctr_y;
  logic                               drawing;

  mcr_pkg::mcr_pix_t expected_points[$];
  int                errors;

  initial begin
    fail_count     = 0;
    points_pending = 0;
    errors         = 0;
  end

  function automatic mcr_pkg::mcr_pix_t mirrored(int dx, int dy, logic last, logic done);
    mcr_pkg::mcr_pix_t p;
    p.pixel_x       = mcr_pkg::COORD_W'(ctr_x + dx);
    p.pixel_y       = mcr_pkg::COORD_W'(ctr_y + dy);
    p.last_of_group = last;
    p.circle_done   = done;
    return p;
  endfunction

  // eight octant points in the block's fixed order
  task automatic queue_octants(logic done);
    int x;
    int y;
    x = arc_x;
    y = arc_y;
    expected_points.push_back(mirrored( x,  y, 1'b0, done));
    expected_points.push_back(mirrored( x, -y, 1'b0, done));
    expected_points.push_back(mirrored(-x, -y, 1'b0, done));
    expected_points.push_back(mirrored(-x,  y, 1'b0, done));
    expected_points.push_back(mirrored( y,  x, 1'b0, done));
    expected_points.push_back(mirrored( y, -x, 1'b0, done));
    expected_points.push_back(mirrored(-y, -x, 1'b0, done));
    expected_points.push_back(mirrored(-y,  x, 1'b1, done));
  endtask

  task automatic predict_item(mcr_pkg::mcr_cmd_t c);
    int   r;
    int   next_d;
    logic done;
    if (c.opcode == mcr_pkg::OP_START) begin
      r        = c.radius;
      ctr_x    = c.center_x;
      ctr_y    = c.center_y;
      arc_x    = '0;
      arc_y    = 13'(r);
      decision = mcr_pkg::DEC_W'(mcr_pkg::DEC_INIT - 2 * r);
      drawing  = 1'b1;
      queue_octants(1'b0);
    end else if (drawing) begin
      if (decision <= 0) begin
        next_d = decision + 4 * arc_x + mcr_pkg::DEC_FLAT_INC;
      end else begin
        next_d = decision + 4 * arc_x - 4 * arc_y + mcr_pkg::DEC_DIAG_INC;
        arc_y  = arc_y - 1;
      end
      decision = mcr_pkg::DEC_W'(next_d);
      arc_x    = arc_x + 1;
      done     = (arc_x > arc_y);
      if (done) begin
        drawing = 1'b0;
      end
      queue_octants(done);
    end
  endtask

  task automatic note_failure(string msg);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    mcr_pkg::mcr_pix_t want;
    if (rst) begin
      expected_points.delete();
      arc_x    = '0;
      arc_y    = '0;
      decision = '0;
      ctr_x    = '0;
      ctr_y    = '0;
      drawing  = 1'b0;
    end else begin
      // check first: a point leaving now never belongs to an item taken now
      if (pix_valid && pix_ready) begin
        if (expected_points.size() == 0) begin
          note_failure($sformatf("unexpected point x=%0d y=%0d last=%0b done=%0b",
                                 pix.pixel_x, pix.pixel_y, pix.last_of_group,
                                 pix.circle_done));
        end else begin
          want = expected_points.pop_front();
          if (pix.pixel_x !== want.pixel_x || pix.pixel_y !== want.pixel_y ||
              pix.last_of_group !== want.last_of_group ||
              pix.circle_done !== want.circle_done) begin
            note_failure($sformatf({"point mismatch: expected x=%0d y=%0d last=%0b done=%0b,",
                                    " got x=%0d y=%0d last=%0b done=%0b"},
              want.pixel_x, want.pixel_y, want.last_of_group, want.circle_done,
              pix.pixel_x, pix.pixel_y, pix.last_of_group, pix.circle_done));
          end
        end
      end
      if (cmd_valid && cmd_ready) begin
        predict_item(cmd);
      end
    end
    fail_count     <= errors;
    points_pending <= expected_points.size();
  end

endmodule

// ===== tb/sv/midpoint_circle_rasterizer_tb.sv =====
// Testbench top for the midpoint circle rasterizer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer_tb;

  // directed part plus random items, about 230 in all
  localparam int N_ITEMS     = 230;
  // tail of the run with no idling on either side
  localparam int QUIET_TAIL  = 40;
  // length of the forced receiver stall that backs up the block
  localparam int LONG_HOLD   = 400;
  // cycles allowed after the last expected point for stragglers
  localparam int DRAIN_CYCLES = 20;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_ready;
  mcr_pkg::mcr_cmd_t cmd = '0;
  logic              pix_valid;
  logic              pix_ready = 1'b0;
  mcr_pkg::mcr_pix_t pix;

  int fail_count;
  int points_pending;

  // flow control knobs, written with NBAs so the other processes see clean values
  bit idle_en   = 1'b1;
  int hold_reqs = 0;
  // items taken by the block so far
  int items_sent = 0;

  always #5 clk = ~clk;

  midpoint_circle_rasterizer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

  mcr_pixel_checker pixel_chk (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd),
    .pix_valid      (pix_valid),
    .pix_ready      (pix_ready),
    .pix            (pix),
    .fail_count     (fail_count),
    .points_pending (points_pending)
  );

  // Offer one item. A random idle gap may come first; valid then
  // stays high with the payload frozen until the block takes the item.
  task automatic send_item(logic op, logic signed [15:0] cx, logic signed [15:0] cy,
                           logic [11:0] r);
    mcr_pkg::mcr_cmd_t c;
    c.opcode   = op;
    c.center_x = cx;
    c.center_y = cy;
    c.radius   = r;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    items_sent++;
  endtask

  // A step ignores the payload fields, so fill them with noise.
  task automatic step_circle();
    send_item(mcr_pkg::OP_STEP, 16'($urandom), 16'($urandom), 12'($urandom));
  endtask

  // Receiver: random stall bursts, plus one long hold on request from the stimulus.
  initial begin
    int stall_left;
    int holds_done;
    stall_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        pix_ready <= 1'b0;
        stall_left--;
      end else if (hold_reqs != holds_done) begin
        // long hold: the two-group queue fills and cmd_ready must drop
        holds_done++;
        stall_left = LONG_HOLD - 1;
        pix_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        pix_ready <= 1'b0;
      end else begin
        pix_ready <= 1'b1;
      end
    end
  end

  // Main stimulus and verdict
  initial begin
    int                 r;
    int                 n_steps;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    bit                 pressured;
    pressured = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // step with no circle running: must produce nothing
    step_circle();
    // zero radius: centre eight times, then the first step completes the circle
    send_item(mcr_pkg::OP_START, 16'sd0, 16'sd0, 12'd0);
    step_circle();
    step_circle();
    // largest radius at the coordinate extremes: points beyond either extreme wrap
    send_item(mcr_pkg::OP_START, 16'sh7FFF, 16'sh8000, 12'hFFF);
    step_circle();
    step_circle();
    // restart while a circle is still running
    send_item(mcr_pkg::OP_START, 16'sh8000, 16'sh7FFF, 12'hFFF);
    step_circle();
    // alternating bit patterns on all fields
    send_item(mcr_pkg::OP_START, 16'sh5555, 16'shAAAA, 12'hAAA);
    step_circle();
    send_item(mcr_pkg::OP_START, 16'shAAAA, 16'sh5555, 12'h555);
    step_circle();
    // radius one finishes on the very first step
    send_item(mcr_pkg::OP_START, 16'sd100, -16'sd100, 12'd1);
    step_circle();
    step_circle();
    // a small circle run to completion, with two idle steps after it
    send_item(mcr_pkg::OP_START, -16'sd1, -16'sd1, 12'd2);
    step_circle();
    step_circle();
    step_circle();
    step_circle();

    // --- random part: mostly whole circles with random content ---
    while (items_sent < N_ITEMS) begin
      if (items_sent >= N_ITEMS - QUIET_TAIL) begin
        idle_en <= 1'b0;
      end
      if (!pressured && items_sent >= N_ITEMS / 2) begin
        pressured = 1'b1;
        hold_reqs <= hold_reqs + 1;
      end

      if ($urandom_range(0, 9) == 0) begin
        // stray step, often with no circle running
        step_circle();
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          // near an edge of the coordinate range, so offsets wrap
          cx = $urandom_range(0, 1) ? 16'(32767 - $urandom_range(0, 30))
                                    : 16'(-32768 + int'($urandom_range(0, 30)));
          cy = $urandom_range(0, 1) ? 16'(32767 - $urandom_range(0, 30))
                                    : 16'(-32768 + int'($urandom_range(0, 30)));
        end else begin
          cx = 16'($urandom);
          cy = 16'($urandom);
        end

        if ($urandom_range(0, 9) == 0) begin
          // full-range radius: only a few steps, then abandoned by the next start
          r       = $urandom_range(0, 4095);
          n_steps = $urandom_range(1, 6);
        end else begin
          // small radius, usually stepped a little past completion
          r       = $urandom_range(0, 24);
          n_steps = r * 3 / 4 + 2;
          if ($urandom_range(0, 3) == 0) begin
            n_steps = $urandom_range(0, n_steps);
          end
        end

        send_item(mcr_pkg::OP_START, cx, cy, 12'(r));
        repeat (n_steps) step_circle();
      end
    end
    cmd_valid <= 1'b0;

    // wait until every predicted point has come out, then a short quiet spell
    do @(posedge clk); while (points_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every item eight points, each
  // point behind a full stall burst, plus the long hold)
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
